// ===== hdl/rm2q_pkg.sv =====
// ----------------------------------------------------------------------------
// rm2q_pkg
// Shared widths, constants and types for the matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rm2q_pkg;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int FRAC_BITS = 14;
    localparam int MAG_MAX   = 32767;

    localparam int SUM_BASE  = (FRAC_BITS + 1 > IN_W) ? FRAC_BITS + 1 : IN_W;
    localparam int SUM_W     = SUM_BASE + 3;
    localparam int MAG_IN_W  = SUM_W - 1;
    localparam int RAD_W     = MAG_IN_W + FRAC_BITS;
    localparam int ROOT_W    = (RAD_W + 1) / 2;
    localparam int RAD_PAD   = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 2;
    localparam int DIFF_W    = IN_W + 1;
    localparam int N_LANES   = 4;
    localparam int LATENCY   = ROOT_W + 2;

    // Lane sign patterns, bits {r00, r11, r22}: 1 subtracts the entry.
    localparam logic [2:0] NEG_W = 3'b000;
    localparam logic [2:0] NEG_X = 3'b011;
    localparam logic [2:0] NEG_Y = 3'b101;
    localparam logic [2:0] NEG_Z = 3'b110;

    localparam int LANE_W = 0;
    localparam int LANE_X = 1;
    localparam int LANE_Y = 2;
    localparam int LANE_Z = 3;

    typedef logic [ROOT_W-1:0] root_t;

    typedef struct packed {
        logic [RAD_PAD-1:0] rad;
        logic [REM_W-1:0]   rem;
        root_t              root;
    } sqrt_word_t;

    typedef struct packed {
        logic x;
        logic y;
        logic z;
    } sign_t;

endpackage

// ===== hdl/rm2q_sqrt_stage.sv =====
// ----------------------------------------------------------------------------
// rm2q_sqrt_stage
// One registered step of the integer square root: one root bit per stage.
// ----------------------------------------------------------------------------
module rm2q_sqrt_stage
    import rm2q_pkg::*;
(
    input  logic       clk,
    input  sqrt_word_t d,
    output sqrt_word_t q
);

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    sqrt_word_t       q_next;

    always_comb
    begin
        rem_sh = {d.rem[REM_W-3:0], d.rad[RAD_PAD-1 -: 2]};
        trial  = {d.root, 2'b01};
        q_next.rad = {d.rad[RAD_PAD-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            q_next.rem  = rem_sh - trial;
            q_next.root = {d.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            q_next.rem  = rem_sh;
            q_next.root = {d.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        q <= q_next;
    end

endmodule

// ===== hdl/rm2q_lane.sv =====
// ----------------------------------------------------------------------------
// rm2q_lane
// One quaternion component: diagonal sum, clamp, pipelined square root.
// ----------------------------------------------------------------------------
module rm2q_lane
    import rm2q_pkg::*;
(
    input  logic                   clk,
    input  logic [2:0]             neg,
    input  logic signed [IN_W-1:0] d0,
    input  logic signed [IN_W-1:0] d1,
    input  logic signed [IN_W-1:0] d2,
    output root_t                  root
);

    localparam logic signed [SUM_W-1:0] ONE = SUM_W'(64'd1 << FRAC_BITS);

    logic signed [SUM_W-1:0] t0;
    logic signed [SUM_W-1:0] t1;
    logic signed [SUM_W-1:0] t2;
    logic signed [SUM_W-1:0] sum;
    logic [MAG_IN_W-1:0]     mag;
    sqrt_word_t              head;
    sqrt_word_t              st [ROOT_W+1];

    always_comb
    begin
        t0   = neg[2] ? -SUM_W'(d0) : SUM_W'(d0);
        t1   = neg[1] ? -SUM_W'(d1) : SUM_W'(d1);
        t2   = neg[0] ? -SUM_W'(d2) : SUM_W'(d2);
        sum  = ONE + t0 + t1 + t2;
        mag  = sum[SUM_W-1] ? '0 : sum[MAG_IN_W-1:0];
        head.rad  = RAD_PAD'({mag, {FRAC_BITS{1'b0}}});
        head.rem  = '0;
        head.root = '0;
    end

    always_ff @(posedge clk)
    begin
        st[0] <= head;
    end

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_stage
        rm2q_sqrt_stage u_stage (
            .clk (clk),
            .d   (st[i]),
            .q   (st[i+1])
        );
    end

    assign root = st[ROOT_W].root;

endmodule

// ===== hdl/rm2q_merge.sv =====
// ----------------------------------------------------------------------------
// rm2q_merge
// Halve, saturate and sign the lane roots into the registered result word.
// ----------------------------------------------------------------------------
module rm2q_merge
    import rm2q_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid,
    input  root_t                   roots [N_LANES],
    input  sign_t                   signs,
    output logic                    done,
    output logic signed [OUT_W-1:0] quat_w,
    output logic signed [OUT_W-1:0] quat_x,
    output logic signed [OUT_W-1:0] quat_y,
    output logic signed [OUT_W-1:0] quat_z
);

    logic [OUT_W-1:0]        mag  [N_LANES];
    logic [N_LANES-1:0]      negs;
    logic signed [OUT_W-1:0] q_next [N_LANES];
    logic                    done_reg;
    logic signed [OUT_W-1:0] q_reg [N_LANES];

    assign negs = {signs.z, signs.y, signs.x, 1'b0};

    always_comb
    begin
        for (int i = 0; i < N_LANES; i++)
        begin
            if (64'(roots[i][ROOT_W-1:1]) > 64'(MAG_MAX))
                mag[i] = OUT_W'(MAG_MAX);
            else
                mag[i] = OUT_W'(roots[i][ROOT_W-1:1]);
            q_next[i] = negs[i] ? -$signed(mag[i]) : $signed(mag[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        if (valid)
            q_reg <= q_next;
    end

    assign done   = done_reg;
    assign quat_w = q_reg[LANE_W];
    assign quat_x = q_reg[LANE_X];
    assign quat_y = q_reg[LANE_Y];
    assign quat_z = q_reg[LANE_Z];

endmodule

// ===== hdl/rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Rotation matrix (signed Q2.14) to unit quaternion (signed Q2.14).
//
// Usage:
//   Drive r00..r22 and pulse start; a word is taken at every rising edge
//   where start is high and busy is low. busy stays low: the block takes a
//   new matrix in every cycle.
//   Four lanes (w, x, y, z) each form their diagonal sum and run a
//   square root pipeline of ROOT_W stages, one root bit per stage; the
//   merge stage halves, saturates and signs the roots.
//   An accepted word passes the lane head register, the ROOT_W root
//   stages and the merge result register, with valid_reg alongside; done
//   comes from the merge stage. Throughput: one word per cycle; the depth
//   of the root pipeline sets the latency, not the rate.
//   done marks quat_w..quat_z for exactly one cycle; the receiver has no
//   way to stall and must take the word then.
//   Reset (rst_n low) clears all in-flight words; no done follows.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
    import rm2q_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [IN_W-1:0]  r00,
    input  logic signed [IN_W-1:0]  r01,
    input  logic signed [IN_W-1:0]  r02,
    input  logic signed [IN_W-1:0]  r10,
    input  logic signed [IN_W-1:0]  r11,
    input  logic signed [IN_W-1:0]  r12,
    input  logic signed [IN_W-1:0]  r20,
    input  logic signed [IN_W-1:0]  r21,
    input  logic signed [IN_W-1:0]  r22,
    output logic                    done,
    output logic signed [OUT_W-1:0] quat_w,
    output logic signed [OUT_W-1:0] quat_x,
    output logic signed [OUT_W-1:0] quat_y,
    output logic signed [OUT_W-1:0] quat_z
);

    localparam logic [2:0] LANE_NEG [N_LANES] = '{NEG_W, NEG_X, NEG_Y, NEG_Z};

    logic                      accept;
    logic [ROOT_W:0]           valid_reg;
    logic [ROOT_W:0]           valid_next;
    sign_t                     sign_reg [ROOT_W+1];
    sign_t                     sign_next;
    logic signed [DIFF_W-1:0]  diff_x;
    logic signed [DIFF_W-1:0]  diff_y;
    logic signed [DIFF_W-1:0]  diff_z;
    root_t                     roots [N_LANES];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        diff_x = DIFF_W'(r21) - DIFF_W'(r12);
        diff_y = DIFF_W'(r02) - DIFF_W'(r20);
        diff_z = DIFF_W'(r10) - DIFF_W'(r01);
        sign_next.x = diff_x[DIFF_W-1];
        sign_next.y = diff_y[DIFF_W-1];
        sign_next.z = diff_z[DIFF_W-1];
        valid_next  = {valid_reg[ROOT_W-1:0], accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        sign_reg[0] <= sign_next;
        for (int i = 1; i <= ROOT_W; i++)
            sign_reg[i] <= sign_reg[i-1];
    end

    for (genvar l = 0; l < N_LANES; l++)
    begin : g_lane
        rm2q_lane u_lane (
            .clk  (clk),
            .neg  (LANE_NEG[l]),
            .d0   (r00),
            .d1   (r11),
            .d2   (r22),
            .root (roots[l])
        );
    end

    rm2q_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (valid_reg[ROOT_W]),
        .roots  (roots),
        .signs  (sign_reg[ROOT_W]),
        .done   (done),
        .quat_w (quat_w),
        .quat_x (quat_x),
        .quat_y (quat_y),
        .quat_z (quat_z)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(LATENCY) done)
        else $error("accepted word did not produce a result on time");

    a_w_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !quat_w[OUT_W-1])
        else $error("quat_w negative");

    a_no_minimum: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (quat_x != {1'b1, {(OUT_W-1){1'b0}}})
              && (quat_y != {1'b1, {(OUT_W-1){1'b0}}})
              && (quat_z != {1'b1, {(OUT_W-1){1'b0}}}))
        else $error("quaternion component outside saturated range");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(valid_reg[ROOT_W]))
        else $error("result without a word in flight");

endmodule

// ===== verif/rotation_matrix_to_quaternion_tb.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb
// Drives 3x3 matrices into the quaternion pipeline: a directed set first.
// The directed set covers identity, half turns, quarter turns, extreme
// entries, clamped sums and zero off-diagonal differences. Random matrices
// follow: near-rotations built from random quaternions, raw full-range words,
// and words made of edge values. The random part runs in three phases of
// sender idling. Each accepted matrix is turned into an expected quaternion
// by an independent fixed-point model. Every done word is compared with it
// field by field.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rm2q_pkg::*;

    localparam int PHASE_WORDS = 540;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [IN_W-1:0] r00;
        logic [IN_W-1:0] r01;
        logic [IN_W-1:0] r02;
        logic [IN_W-1:0] r10;
        logic [IN_W-1:0] r11;
        logic [IN_W-1:0] r12;
        logic [IN_W-1:0] r20;
        logic [IN_W-1:0] r21;
        logic [IN_W-1:0] r22;
    } matrix_t;

    typedef struct packed {
        logic [OUT_W-1:0] w;
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic [OUT_W-1:0] z;
    } quat_t;

    class quaternion_board;
        quat_t expected_quats[$];
        int    errors;

        function new();
            errors = 0;
        endfunction

        function logic [OUT_W-1:0] half_root(longint s);
            longint unsigned rad;
            longint unsigned root;
            longint unsigned bitv;
            if (s < 0)
                s = 0;
            rad  = longint'(s) << FRAC_BITS;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > rad)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (rad >= root + bitv)
                begin
                    rad  = rad - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            root = root >> 1;
            if (root > MAG_MAX)
                root = MAG_MAX;
            return root[OUT_W-1:0];
        endfunction

        function quat_t predict_quat(matrix_t m);
            longint one;
            longint a00;
            longint a11;
            longint a22;
            quat_t  q;
            one = longint'(1) << FRAC_BITS;
            a00 = longint'($signed(m.r00));
            a11 = longint'($signed(m.r11));
            a22 = longint'($signed(m.r22));
            q.w = half_root(one + a00 + a11 + a22);
            q.x = half_root(one + a00 - a11 - a22);
            q.y = half_root(one - a00 + a11 - a22);
            q.z = half_root(one - a00 - a11 + a22);
            if (longint'($signed(m.r21)) - longint'($signed(m.r12)) < 0)
                q.x = -q.x;
            if (longint'($signed(m.r02)) - longint'($signed(m.r20)) < 0)
                q.y = -q.y;
            if (longint'($signed(m.r10)) - longint'($signed(m.r01)) < 0)
                q.z = -q.z;
            return q;
        endfunction

        function void note_matrix(matrix_t m);
            expected_quats.push_back(predict_quat(m));
        endfunction

        function void check_quat(quat_t got);
            quat_t want;
            if (expected_quats.size() == 0)
            begin
                $error("unexpected quaternion word: w %0d x %0d y %0d z %0d",
                       $signed(got.w), $signed(got.x), $signed(got.y), $signed(got.z));
                errors++;
                return;
            end
            want = expected_quats.pop_front();
            if (got.w !== want.w)
            begin
                $error("quat_w mismatch: expected %0d, actual %0d",
                       $signed(want.w), $signed(got.w));
                errors++;
            end
            if (got.x !== want.x)
            begin
                $error("quat_x mismatch: expected %0d, actual %0d",
                       $signed(want.x), $signed(got.x));
                errors++;
            end
            if (got.y !== want.y)
            begin
                $error("quat_y mismatch: expected %0d, actual %0d",
                       $signed(want.y), $signed(got.y));
                errors++;
            end
            if (got.z !== want.z)
            begin
                $error("quat_z mismatch: expected %0d, actual %0d",
                       $signed(want.z), $signed(got.z));
                errors++;
            end
        endfunction

        function int pending();
            return expected_quats.size();
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic signed [IN_W-1:0]  r00;
    logic signed [IN_W-1:0]  r01;
    logic signed [IN_W-1:0]  r02;
    logic signed [IN_W-1:0]  r10;
    logic signed [IN_W-1:0]  r11;
    logic signed [IN_W-1:0]  r12;
    logic signed [IN_W-1:0]  r20;
    logic signed [IN_W-1:0]  r21;
    logic signed [IN_W-1:0]  r22;
    logic                    done;
    logic signed [OUT_W-1:0] quat_w;
    logic signed [OUT_W-1:0] quat_x;
    logic signed [OUT_W-1:0] quat_y;
    logic signed [OUT_W-1:0] quat_z;

    quaternion_board board;
    int              stall_cycles;

    rotation_matrix_to_quaternion dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .r00    (r00),
        .r01    (r01),
        .r02    (r02),
        .r10    (r10),
        .r11    (r11),
        .r12    (r12),
        .r20    (r20),
        .r21    (r21),
        .r22    (r22),
        .done   (done),
        .quat_w (quat_w),
        .quat_x (quat_x),
        .quat_y (quat_y),
        .quat_z (quat_z)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_quat({quat_w, quat_x, quat_y, quat_z});
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic matrix_t make_matrix(int a00, int a01, int a02,
                                            int a10, int a11, int a12,
                                            int a20, int a21, int a22);
        matrix_t m;
        m.r00 = a00[IN_W-1:0];
        m.r01 = a01[IN_W-1:0];
        m.r02 = a02[IN_W-1:0];
        m.r10 = a10[IN_W-1:0];
        m.r11 = a11[IN_W-1:0];
        m.r12 = a12[IN_W-1:0];
        m.r20 = a20[IN_W-1:0];
        m.r21 = a21[IN_W-1:0];
        m.r22 = a22[IN_W-1:0];
        return m;
    endfunction

    function automatic logic [IN_W-1:0] to_fixed(real v);
        int k;
        k = $rtoi(v * real'(1 << FRAC_BITS)) + int'($urandom_range(0, 6)) - 3;
        if (k > 32767)
            k = 32767;
        if (k < -32768)
            k = -32768;
        return k[IN_W-1:0];
    endfunction

    function automatic matrix_t random_rotation();
        real     qw;
        real     qx;
        real     qy;
        real     qz;
        real     n;
        matrix_t m;
        qw = real'(int'($urandom_range(0, 2000)) - 1000);
        qx = real'(int'($urandom_range(0, 2000)) - 1000);
        qy = real'(int'($urandom_range(0, 2000)) - 1000);
        qz = real'(int'($urandom_range(0, 2000)) - 1000);
        n  = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
        if (n == 0.0)
        begin
            qw = 1.0;
            n  = 1.0;
        end
        qw = qw / n;
        qx = qx / n;
        qy = qy / n;
        qz = qz / n;
        m.r00 = to_fixed(1.0 - 2.0 * (qy * qy + qz * qz));
        m.r01 = to_fixed(2.0 * (qx * qy - qz * qw));
        m.r02 = to_fixed(2.0 * (qx * qz + qy * qw));
        m.r10 = to_fixed(2.0 * (qx * qy + qz * qw));
        m.r11 = to_fixed(1.0 - 2.0 * (qx * qx + qz * qz));
        m.r12 = to_fixed(2.0 * (qy * qz - qx * qw));
        m.r20 = to_fixed(2.0 * (qx * qz - qy * qw));
        m.r21 = to_fixed(2.0 * (qy * qz + qx * qw));
        m.r22 = to_fixed(1.0 - 2.0 * (qx * qx + qy * qy));
        return m;
    endfunction

    function automatic logic [IN_W-1:0] edge_entry();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'h0001;
            5: return 16'h4000;
            6: return 16'hC000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic matrix_t random_matrix();
        int           pick;
        logic [159:0] raw;
        matrix_t      m;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return random_rotation();
        if (pick < 85)
        begin
            raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            m   = raw[$bits(matrix_t)-1:0];
            return m;
        end
        m = {edge_entry(), edge_entry(), edge_entry(), edge_entry(), edge_entry(),
             edge_entry(), edge_entry(), edge_entry(), edge_entry()};
        return m;
    endfunction

    task automatic send_matrix(matrix_t m);
        start <= 1'b1;
        r00   <= m.r00;
        r01   <= m.r01;
        r02   <= m.r02;
        r10   <= m.r10;
        r11   <= m.r11;
        r12   <= m.r12;
        r20   <= m.r20;
        r21   <= m.r21;
        r22   <= m.r22;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_matrix(m);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int idle_pct, int words);
        for (int i = 0; i < words; i++)
        begin
            while ($urandom_range(0, 99) < idle_pct)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
            send_matrix(random_matrix());
        end
    endtask

    initial
    begin
        board = new();
        rst_n <= 1'b0;
        start <= 1'b0;
        r00   <= '0;
        r01   <= '0;
        r02   <= '0;
        r10   <= '0;
        r11   <= '0;
        r12   <= '0;
        r20   <= '0;
        r21   <= '0;
        r22   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_matrix(make_matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        send_matrix(make_matrix(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        send_matrix(make_matrix(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
        send_matrix(make_matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
        send_matrix(make_matrix(0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
        send_matrix(make_matrix(0, 16384, 0, -16384, 0, 0, 0, 0, 16384));
        send_matrix(make_matrix(16384, 0, 0, 0, 0, -16384, 0, 16384, 0));
        send_matrix(make_matrix(0, 0, -16384, 0, 16384, 0, 16384, 0, 0));
        send_matrix(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_matrix(make_matrix(32767, 32767, 32767, 32767, 32767,
                                32767, 32767, 32767, 32767));
        send_matrix(make_matrix(-32768, -32768, -32768, -32768, -32768,
                                -32768, -32768, -32768, -32768));
        send_matrix(make_matrix(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
        send_matrix(make_matrix(32767, 0, 0, 0, -32768, 0, 0, 0, -32768));
        send_matrix(make_matrix(-32768, 0, 0, 0, 32767, 0, 0, 0, -32768));
        send_matrix(make_matrix(-32768, 0, 0, 0, -32768, 0, 0, 0, 32767));
        send_matrix(make_matrix(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
        send_matrix(make_matrix(-16384, 100, -100, 100, 0, 100, 100, -100, 0));
        send_matrix(make_matrix(0, 0, 5, 0, -16384, 0, 5, 0, 0));
        send_matrix(make_matrix(0, 7, 0, 7, 0, 0, 0, 0, -16384));
        send_matrix(make_matrix(0, 32767, -32768, -32768, 0, -32768,
                                32767, 32767, 0));
        send_matrix(make_matrix(0, -32768, 32767, 32767, 0, 32767,
                                -32768, -32768, 0));
        send_matrix(make_matrix(8192, -1, 1, 1, 8192, -1, -1, 1, 8192));
        send_matrix(make_matrix(-1, 0, 0, 0, -1, 0, 0, 0, -1));
        drain();

        run_phase(19, PHASE_WORDS);
        drain();
        run_phase(48, PHASE_WORDS);
        drain();
        run_phase(0, PHASE_WORDS);
        drain();
        repeat (LATENCY + 4) @(posedge clk);

        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
